@@ hw/rtl/mceb_pkg.sv @@
// ----------------------------------------------------------------------------
// mceb_pkg
// Shared types and constants for the mask colour-expansion blit.
// ----------------------------------------------------------------------------
package mceb_pkg;

  // Register file geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned ADDR_W     = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR    = 3'd7;

  // Reset values
  localparam logic [DIM_W-1:0]   DEST_WIDTH_RST  = 13'd320;
  localparam logic [DIM_W-1:0]   DEST_HEIGHT_RST = 13'd240;
  localparam logic [DIM_W-1:0]   RECT_WIDTH_RST  = 13'd3;
  localparam logic [DIM_W-1:0]   RECT_HEIGHT_RST = 13'd6;
  localparam logic [DIM_W-1:0]   OFFSET_RST      = 13'd0;
  localparam logic [COLOR_W-1:0] FG_COLOR_RST    = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST    = 32'h0000_0000;

  // Mask value that selects the background colour
  localparam logic [PIXEL_W-1:0] BG_KEY = 32'hFFFF_FFFF;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0]   dest_width;
    logic [DIM_W-1:0]   dest_height;
    logic [DIM_W-1:0]   rect_width;
    logic [DIM_W-1:0]   rect_height;
    logic [DIM_W-1:0]   x_offset;
    logic [DIM_W-1:0]   y_offset;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
  } mceb_cfg_t;

endpackage

@@ hw/rtl/mceb_regs.sv @@
// ----------------------------------------------------------------------------
// mceb_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mceb_regs
  import mceb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output mceb_cfg_t             cfg
);

  mceb_cfg_t cfg_r;
  mceb_cfg_t cfg_nxt;

  // Decode the write; narrow registers keep the low bits of the data.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_WIDTH:  cfg_nxt.dest_width  = cfg_wdata[DIM_W-1:0];
        REG_DEST_HEIGHT: cfg_nxt.dest_height = cfg_wdata[DIM_W-1:0];
        REG_RECT_WIDTH:  cfg_nxt.rect_width  = cfg_wdata[DIM_W-1:0];
        REG_RECT_HEIGHT: cfg_nxt.rect_height = cfg_wdata[DIM_W-1:0];
        REG_X_OFFSET:    cfg_nxt.x_offset    = cfg_wdata[DIM_W-1:0];
        REG_Y_OFFSET:    cfg_nxt.y_offset    = cfg_wdata[DIM_W-1:0];
        REG_FG_COLOR:    cfg_nxt.fg_color    = cfg_wdata[COLOR_W-1:0];
        REG_BG_COLOR:    cfg_nxt.bg_color    = cfg_wdata[COLOR_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_width  <= DEST_WIDTH_RST;
      cfg_r.dest_height <= DEST_HEIGHT_RST;
      cfg_r.rect_width  <= RECT_WIDTH_RST;
      cfg_r.rect_height <= RECT_HEIGHT_RST;
      cfg_r.x_offset    <= OFFSET_RST;
      cfg_r.y_offset    <= OFFSET_RST;
      cfg_r.fg_color    <= FG_COLOR_RST;
      cfg_r.bg_color    <= BG_COLOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/mceb_pos.sv @@
// ----------------------------------------------------------------------------
// mceb_pos
// Input register and raster position counters over the rectangle.
// ----------------------------------------------------------------------------
module mceb_pos
  import mceb_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
)
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  mceb_cfg_t                    cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [PIXEL_W-1:0]           in_pixel,
  output logic                         s1_valid,
  input  logic                         s1_ready,
  output logic [PIXEL_W-1:0]           s1_pixel,
  output logic [$clog2(MAX_DIM)-1:0]   s1_col,
  output logic [$clog2(MAX_DIM)-1:0]   s1_row,
  output logic                         s1_last
);

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned EW = ((CW > DIM_W) ? CW : DIM_W) + 1;
  localparam logic [EW-1:0] MAX_E = EW'(MAX_DIM);

  logic          valid_r;
  logic [PIXEL_W-1:0] pixel_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] s1_col_r;
  logic [CW-1:0] s1_row_r;
  logic          last_r;
  logic          accept;
  logic [EW-1:0] col_lim, row_lim;
  logic          last_col, last_row;

  assign in_ready = !valid_r || s1_ready;
  assign accept   = in_valid && in_ready;

  // Last column and row, with the rectangle size clamped to 1..MAX_DIM.
  always_comb begin
    if (cfg.rect_width == '0) begin
      col_lim = '0;
    end else if (EW'(cfg.rect_width) >= MAX_E) begin
      col_lim = MAX_E - EW'(1);
    end else begin
      col_lim = EW'(cfg.rect_width) - EW'(1);
    end
    if (cfg.rect_height == '0) begin
      row_lim = '0;
    end else if (EW'(cfg.rect_height) >= MAX_E) begin
      row_lim = MAX_E - EW'(1);
    end else begin
      row_lim = EW'(cfg.rect_height) - EW'(1);
    end
    last_col = (EW'(col_r) >= col_lim);
    last_row = (EW'(row_r) >= row_lim);
  end

  // Raster advance: wrap the column at the row end, the row at the rectangle end.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_ready) begin
        valid_r <= in_valid;
      end
    end
  end

  // Payload of the input register, captured on each transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_r  <= in_pixel;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
      last_r   <= last_col && last_row;
    end
  end

  assign s1_valid = valid_r;
  assign s1_pixel = pixel_r;
  assign s1_col   = s1_col_r;
  assign s1_row   = s1_row_r;
  assign s1_last  = last_r;

endmodule

@@ hw/rtl/mceb_calc.sv @@
// ----------------------------------------------------------------------------
// mceb_calc
// Clipping, colour selection and address generation into the result register.
// ----------------------------------------------------------------------------
module mceb_calc
  import mceb_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
)
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  mceb_cfg_t                  cfg,
  input  logic                       s1_valid,
  output logic                       s1_ready,
  input  logic [PIXEL_W-1:0]         s1_pixel,
  input  logic [$clog2(MAX_DIM)-1:0] s1_col,
  input  logic [$clog2(MAX_DIM)-1:0] s1_row,
  input  logic                       s1_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ADDR_W-1:0]          out_addr,
  output logic [COLOR_W-1:0]         out_color,
  output logic                       out_enable,
  output logic                       out_done
);

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned PW = ((CW > DIM_W) ? CW : DIM_W) + 1;
  localparam int unsigned MW = PW + DIM_W;

  logic               valid_r;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               enable_r, enable_nxt;
  logic               done_r;
  logic [PW-1:0]      xp, yp;
  logic [MW-1:0]      row_base;
  logic               in_dest;

  assign s1_ready = !valid_r || out_ready;

  // Destination position and clip test.
  always_comb begin
    xp       = PW'(s1_col) + PW'(cfg.x_offset);
    yp       = PW'(s1_row) + PW'(cfg.y_offset);
    in_dest  = (xp < PW'(cfg.dest_width)) && (yp < PW'(cfg.dest_height));
    row_base = MW'(yp) * MW'(cfg.dest_width);
  end

  // Colour selection; a transparent background or a clipped pixel writes nothing.
  always_comb begin
    enable_nxt = 1'b0;
    color_nxt  = '0;
    addr_nxt   = '0;
    if (in_dest) begin
      if (s1_pixel == BG_KEY) begin
        if (cfg.bg_color[COLOR_W-1:16] != '0) begin
          enable_nxt = 1'b1;
          color_nxt  = cfg.bg_color;
        end
      end else begin
        enable_nxt = 1'b1;
        color_nxt  = cfg.fg_color;
      end
    end
    if (enable_nxt) begin
      addr_nxt = ADDR_W'(xp) + row_base[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s1_ready) begin
      valid_r <= s1_valid;
    end
  end

  // Result register, loaded on each transfer from the input register.
  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      addr_r   <= addr_nxt;
      color_r  <= color_nxt;
      enable_r <= enable_nxt;
      done_r   <= s1_last;
    end
  end

  assign out_valid  = valid_r;
  assign out_addr   = addr_r;
  assign out_color  = color_r;
  assign out_enable = enable_r;
  assign out_done   = done_r;

endmodule

@@ hw/rtl/mask_color_expand_blit.sv @@
// ----------------------------------------------------------------------------
// mask_color_expand_blit
// Monochrome colour-expansion blit: mask pixels in, framebuffer writes out.
// ----------------------------------------------------------------------------
// Usage:
// The in_ stream carries the rectangle's mask pixels in raster order, one per
// transfer. Each transfer yields exactly one transfer on the out_ stream: the
// destination address and colour, a write-enable flag in out_tuser (low for
// clipped or transparent pixels, with address and colour zero) and out_tlast
// on the last pixel of the rectangle.
// A pixel passes through the input register and then the result register
// before its output transfer. One pixel is taken every cycle while the receiver
// keeps up; the rate is set by the two register stages, each of which accepts
// a new pixel whenever its successor can move on.
// When the receiver stalls, the result register holds and the input register
// fills, after which in_tready drops; nothing is lost.
// Reset loads the register defaults (320 x 240 destination, 3 x 6 rectangle,
// zero offsets, white foreground, transparent background), clears both stages
// and sets the position counters to the rectangle's first pixel.
// Users must write registers through cfg_ only while idle; the block does not check.
// ----------------------------------------------------------------------------
module mask_color_expand_blit
  import mceb_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Mask pixel stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // [31:0] src_pixel
  // Framebuffer write stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata,  // [23:0] write_addr, [55:24] write_color
  output logic                  out_tuser,  // [0] write_enable
  output logic                  out_tlast   // rect_done
);

  localparam int unsigned CW = $clog2(MAX_DIM);

  mceb_cfg_t          cfg;
  logic               s1_valid;
  logic               s1_ready;
  logic [PIXEL_W-1:0] s1_pixel;
  logic [CW-1:0]      s1_col;
  logic [CW-1:0]      s1_row;
  logic               s1_last;
  logic [ADDR_W-1:0]  res_addr;
  logic [COLOR_W-1:0] res_color;

  // Register file
  mceb_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register and position counters
  mceb_pos #(
    .MAX_DIM (MAX_DIM)
  ) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pixel (in_tdata),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_pixel (s1_pixel),
    .s1_col   (s1_col),
    .s1_row   (s1_row),
    .s1_last  (s1_last)
  );

  // Clip, colour and address into the result register
  mceb_calc #(
    .MAX_DIM (MAX_DIM)
  ) u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_pixel   (s1_pixel),
    .s1_col     (s1_col),
    .s1_row     (s1_row),
    .s1_last    (s1_last),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_addr   (res_addr),
    .out_color  (res_color),
    .out_enable (out_tuser),
    .out_done   (out_tlast)
  );

  // Pack the result fields, address in the low bits.
  assign out_tdata = {res_color, res_addr};

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mask colour-expansion blit.
// A behavioural copy of the blit predicts one framebuffer write for every mask
// pixel taken in, and each write leaving the block is compared against it.
// Directed pixels cover the register defaults, clipping, transparency, size
// clamping and address wrap. Random rectangles follow under three idling
// patterns, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import mceb_pkg::*;

  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ADDR_MASK   = 32'h00FF_FFFF;

  // One framebuffer write as seen on the result stream
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               enable;
    logic               done;
  } fb_write_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;   // [31:0] src_pixel
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [55:0]           out_tdata;  // [23:0] write_addr, [55:24] write_color
  logic                  out_tuser;  // [0] write_enable
  logic                  out_tlast;

  // Model state: register copy and rectangle position
  mceb_cfg_t   blit_cfg;
  int unsigned col_pos;
  int unsigned row_pos;
  fb_write_t   pending_writes[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned src_gap_pct    = 0;
  int unsigned out_stall_pct  = 0;
  int unsigned holdoff_cycles = 0;

  mask_color_expand_blit #(.MAX_DIM(MAX_DIM)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock generation: 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: a counted hold-off takes priority over random stalls.
  always @(negedge clk) begin
    if (holdoff_cycles > 0) begin
      out_tready = 1'b0;
      holdoff_cycles--;
    end else begin
      out_tready = ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Compare every write transfer with the oldest predicted write.
  always @(posedge clk) begin
    fb_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write transfer: addr %0h color %0h", out_tdata[23:0],
               out_tdata[55:24]);
        mismatch_count++;
      end else begin
        want = pending_writes.pop_front();
        if (out_tdata[23:0] !== want.addr) begin
          $error("write_addr: expected %0h, got %0h", want.addr, out_tdata[23:0]);
          mismatch_count++;
        end
        if (out_tdata[55:24] !== want.color) begin
          $error("write_color: expected %0h, got %0h", want.color, out_tdata[55:24]);
          mismatch_count++;
        end
        if (out_tuser !== want.enable) begin
          $error("write_enable: expected %0b, got %0b", want.enable, out_tuser);
          mismatch_count++;
        end
        if (out_tlast !== want.done) begin
          $error("rect_done: expected %0b, got %0b", want.done, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // Predict the write for one accepted mask pixel and step the position.
  task automatic expand_pixel(input logic [PIXEL_W-1:0] pix);
    fb_write_t   wr;
    int unsigned w;
    int unsigned h;
    int unsigned xp;
    int unsigned yp;
    int unsigned lin;
    logic        in_dest;
    logic        last_col;
    logic        last_row;
    w  = clamp_dim(blit_cfg.rect_width);
    h  = clamp_dim(blit_cfg.rect_height);
    xp = col_pos + blit_cfg.x_offset;
    yp = row_pos + blit_cfg.y_offset;
    in_dest  = (xp < blit_cfg.dest_width) && (yp < blit_cfg.dest_height);
    last_col = (col_pos >= w - 1);
    last_row = (row_pos >= h - 1);
    wr = '0;
    if (in_dest) begin
      if (pix == BG_KEY) begin
        if (blit_cfg.bg_color[31:16] != '0) begin
          wr.enable = 1'b1;
          wr.color  = blit_cfg.bg_color;
        end
      end else begin
        wr.enable = 1'b1;
        wr.color  = blit_cfg.fg_color;
      end
    end
    if (wr.enable) begin
      lin = (xp + yp * blit_cfg.dest_width) & ADDR_MASK;
      wr.addr = lin[ADDR_W-1:0];
    end
    wr.done = last_col && last_row;
    pending_writes.push_back(wr);
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // Offer one mask pixel and wait for its transfer; valid stays high after.
  task automatic send_mask_pixel(input logic [PIXEL_W-1:0] pix);
    if ($urandom_range(99) < src_gap_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = pix;
    do @(posedge clk); while (!in_tready);
    expand_pixel(pix);
    @(negedge clk);
  endtask

  // Stop offering pixels and wait until every predicted write has arrived.
  task automatic wait_writes_done();
    in_tvalid = 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
  endtask

  // Write all eight registers; unused upper bits of the size registers get junk.
  task automatic program_blit(input mceb_cfg_t s);
    logic [CFG_DATA_W-1:0] vals [8];
    int unsigned           i;
    for (i = 0; i < 8; i++) vals[i] = $urandom;
    vals[REG_DEST_WIDTH][DIM_W-1:0]  = s.dest_width;
    vals[REG_DEST_HEIGHT][DIM_W-1:0] = s.dest_height;
    vals[REG_RECT_WIDTH][DIM_W-1:0]  = s.rect_width;
    vals[REG_RECT_HEIGHT][DIM_W-1:0] = s.rect_height;
    vals[REG_X_OFFSET][DIM_W-1:0]    = s.x_offset;
    vals[REG_Y_OFFSET][DIM_W-1:0]    = s.y_offset;
    vals[REG_FG_COLOR]               = s.fg_color;
    vals[REG_BG_COLOR]               = s.bg_color;
    for (i = 0; i < 8; i++) begin
      cfg_we    = 1'b1;
      cfg_index = CFG_IDX_W'(i);
      cfg_wdata = vals[i];
      @(negedge clk);
    end
    cfg_we   = 1'b0;
    blit_cfg = s;
  endtask

  function automatic logic [PIXEL_W-1:0] random_mask_pixel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return BG_KEY;
    if (pick < 60) return BG_KEY ^ (32'h1 << $urandom_range(31));
    return $urandom;
  endfunction

  function automatic logic [COLOR_W-1:0] random_bg_color();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom;
    if (pick < 75) return {16'h0000, 16'($urandom)};
    return {16'($urandom), 16'h0000};
  endfunction

  // Mostly small rectangles near the destination edges, some wild settings.
  function automatic mceb_cfg_t random_setup();
    mceb_cfg_t   s;
    int unsigned pick;
    s.fg_color = $urandom;
    s.bg_color = random_bg_color();
    pick = $urandom_range(99);
    if (pick < 8) begin
      s.rect_width = '0;
    end else if (pick < 12) begin
      s.rect_width = DIM_W'($urandom);
    end else begin
      s.rect_width = DIM_W'($urandom_range(1, 8));
    end
    pick = $urandom_range(99);
    if (pick < 8) begin
      s.rect_height = '0;
    end else if (pick < 12) begin
      s.rect_height = DIM_W'($urandom);
    end else begin
      s.rect_height = DIM_W'($urandom_range(1, 8));
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      s.dest_width  = DIM_W'($urandom_range(1, 24));
      s.dest_height = DIM_W'($urandom_range(1, 24));
      s.x_offset    = DIM_W'($urandom_range(0, s.dest_width + 2));
      s.y_offset    = DIM_W'($urandom_range(0, s.dest_height + 2));
    end else if (pick < 80) begin
      s.dest_width  = ($urandom_range(1) == 0) ? '0 : DIM_W'($urandom_range(1, 64));
      s.dest_height = ($urandom_range(1) == 0) ? '0 : DIM_W'($urandom_range(1, 64));
      s.x_offset    = DIM_W'($urandom_range(0, 8));
      s.y_offset    = DIM_W'($urandom_range(0, 8));
    end else begin
      s.dest_width  = DIM_W'($urandom);
      s.dest_height = DIM_W'($urandom);
      s.x_offset    = DIM_W'($urandom);
      s.y_offset    = DIM_W'($urandom);
    end
    return s;
  endfunction

  // Register defaults: 3 x 6 rectangle into 320 x 240, transparent background.
  task automatic test_reset_defaults();
    send_mask_pixel(32'h0000_0000);
    send_mask_pixel(BG_KEY);
    send_mask_pixel(BG_KEY ^ 32'h1);
    send_mask_pixel(32'h7FFF_FFFF);
    wait_writes_done();
  endtask

  // Shrinking the rectangle mid-way: a column beyond the new edge is the last.
  task automatic test_midrect_shrink();
    mceb_cfg_t s;
    s = blit_cfg;
    s.rect_width = 13'd1;
    s.bg_color   = 32'h0001_0000;
    program_blit(s);
    send_mask_pixel(BG_KEY);
    send_mask_pixel(32'h8000_0000);
    wait_writes_done();
  endtask

  // A zero destination width or height clips everything.
  task automatic test_zero_destination();
    mceb_cfg_t s;
    s = blit_cfg;
    s.dest_width = '0;
    program_blit(s);
    send_mask_pixel(32'h0000_1234);
    wait_writes_done();
    s.dest_width  = 13'd320;
    s.dest_height = '0;
    program_blit(s);
    send_mask_pixel(BG_KEY);
    wait_writes_done();
  endtask

  // Rectangle sizes of zero and beyond the maximum are clamped.
  task automatic test_rect_clamp();
    mceb_cfg_t s;
    s = blit_cfg;
    s.dest_height = 13'd240;
    s.rect_width  = '0;
    s.rect_height = '0;
    program_blit(s);
    send_mask_pixel(32'h0000_0001);
    send_mask_pixel(BG_KEY);
    wait_writes_done();
    s.rect_width  = 13'h1FFF;
    s.rect_height = 13'h1FFF;
    program_blit(s);
    send_mask_pixel(32'hFFFF_0000);
    send_mask_pixel(32'h0000_FFFF);
    wait_writes_done();
  endtask

  // Far corner of the largest destination: address wraps, the last row clips.
  task automatic test_address_wrap();
    mceb_cfg_t s;
    s = blit_cfg;
    s.dest_width  = 13'h1FFF;
    s.dest_height = 13'h1FFF;
    s.rect_width  = 13'd4;
    s.rect_height = 13'd2;
    s.x_offset    = 13'd8000;
    s.y_offset    = 13'd8190;
    s.fg_color    = 32'hA5A5_5A5A;
    program_blit(s);
    send_mask_pixel(32'h1111_1111);
    send_mask_pixel(32'h2222_2222);
    send_mask_pixel(32'h3333_3333);
    wait_writes_done();
    s.rect_width  = 13'd2;
    s.rect_height = 13'd1;
    s.x_offset    = 13'd8190;
    s.y_offset    = 13'h1FFF;
    program_blit(s);
    send_mask_pixel(32'h0);
    send_mask_pixel(32'h0);
    wait_writes_done();
  endtask

  // Background colour with only low bits set is transparent; high bits write.
  task automatic test_background_colour();
    mceb_cfg_t s;
    s = blit_cfg;
    s.dest_width  = 13'd320;
    s.dest_height = 13'd240;
    s.rect_width  = 13'd2;
    s.rect_height = 13'd2;
    s.x_offset    = 13'd5;
    s.y_offset    = 13'd7;
    s.bg_color    = 32'h0000_FFFF;
    program_blit(s);
    send_mask_pixel(BG_KEY);
    send_mask_pixel(32'h0);
    wait_writes_done();
    s.bg_color = 32'hFFFF_0000;
    program_blit(s);
    send_mask_pixel(BG_KEY);
    send_mask_pixel(32'hFFFF_FFFE);
    wait_writes_done();
  endtask

  // Long output hold-off while pixels keep coming, so the input stalls.
  task automatic test_output_holdoff();
    mceb_cfg_t s;
    int unsigned i;
    s = random_setup();
    s.rect_width  = 13'd5;
    s.rect_height = 13'd4;
    program_blit(s);
    holdoff_cycles = 150;
    for (i = 0; i < 40; i++) send_mask_pixel(random_mask_pixel());
    wait_writes_done();
  endtask

  // Random rectangles, mostly sent whole, some cut short before a new setup.
  task automatic test_random_rects(input int unsigned n_pixels, input int unsigned gap_pct,
                                   input int unsigned stall_pct);
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned pos;
    int unsigned count;
    int unsigned i;
    src_gap_pct   = gap_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_pixels) begin
      wait_writes_done();
      program_blit(random_setup());
      w   = clamp_dim(blit_cfg.rect_width);
      h   = clamp_dim(blit_cfg.rect_height);
      pos = (col_pos < w && row_pos < h) ? row_pos * w + col_pos : 0;
      count = w * h - pos;
      if ($urandom_range(99) < 15) count = $urandom_range(1, count);
      if (count > 80) count = $urandom_range(1, 80);
      for (i = 0; i < count; i++) send_mask_pixel(random_mask_pixel());
      sent += count;
    end
    wait_writes_done();
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    blit_cfg.dest_width  = DEST_WIDTH_RST;
    blit_cfg.dest_height = DEST_HEIGHT_RST;
    blit_cfg.rect_width  = RECT_WIDTH_RST;
    blit_cfg.rect_height = RECT_HEIGHT_RST;
    blit_cfg.x_offset    = OFFSET_RST;
    blit_cfg.y_offset    = OFFSET_RST;
    blit_cfg.fg_color    = FG_COLOR_RST;
    blit_cfg.bg_color    = BG_COLOR_RST;
    col_pos = 0;
    row_pos = 0;
    src_gap_pct   = 13;
    out_stall_pct = 59;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_midrect_shrink();
    test_zero_destination();
    test_rect_clamp();
    test_address_wrap();
    test_background_colour();
    test_random_rects(470, 13, 59);
    test_output_holdoff();
    test_random_rects(460, 59, 13);
    test_random_rects(460, 0, 0);

    wait_writes_done();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
